// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled while in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// atr_pkg
// Shared constants and types of the tilt and rate unit.
// ----------------------------------------------------------------------------
package atr_pkg;

  localparam int unsigned CordicSteps = 22;
  localparam int unsigned CordicW     = 36;
  localparam int unsigned AccW        = 24;
  localparam int unsigned StepW       = 5;

  localparam logic signed [AccW-1:0] Deg180Fine  = 24'sd5898240;
  localparam logic signed [15:0]     AngleLimit  = 16'sd23040;
  localparam logic [13:0]            TolReset    = 14'd1638;
  localparam logic [14:0]            OneG        = 15'd16383;

  // Divider widths: dividend |delta|*1e6 (<2^36) plus half elapsed.
  localparam int unsigned DivNumW = 37;
  localparam int unsigned DivDenW = 20;
  localparam int unsigned DivCntW = 6;

  // atan(2^-i) in 1/32768 degree.
  function automatic logic [AccW-1:0] atan_fine(input logic [StepW-1:0] i);
    logic [AccW-1:0] r;
    r = '0;
    case (i)
      5'd0:  r = 24'd1474560;
      5'd1:  r = 24'd870484;
      5'd2:  r = 24'd459940;
      5'd3:  r = 24'd233473;
      5'd4:  r = 24'd117189;
      5'd5:  r = 24'd58652;
      5'd6:  r = 24'd29333;
      5'd7:  r = 24'd14667;
      5'd8:  r = 24'd7334;
      5'd9:  r = 24'd3667;
      5'd10: r = 24'd1833;
      5'd11: r = 24'd917;
      5'd12: r = 24'd458;
      5'd13: r = 24'd229;
      5'd14: r = 24'd115;
      5'd15: r = 24'd57;
      5'd16: r = 24'd29;
      5'd17: r = 24'd14;
      5'd18: r = 24'd7;
      5'd19: r = 24'd4;
      5'd20: r = 24'd2;
      5'd21: r = 24'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StMag    = 8'b0000_0010,
    StPitch  = 8'b0000_0100,
    StRoll   = 8'b0000_1000,
    StPRate  = 8'b0001_0000,
    StRRate  = 8'b0010_0000,
    StOut    = 8'b0100_0000,
    StSq     = 8'b1000_0000
  } atr_state_e;

endpackage

// ===== hw/rtl/accel_tilt_and_rate_unit.sv =====
// Sequence per accepted item: three squares, a band compare, two 22-step
// CORDIC passes and two 37-step divisions in turn.
// The block takes no new item while busy and none while a result waits; the
// CORDIC and the divider are shared by the pitch and roll passes.
// Reset: asynchronous, active low; tolerance returns to 1638 and the stored
// previous angles to zero.
// ----------------------------------------------------------------------------
// accel_tilt_and_rate_unit
// Tilt angles, angle rates and linear-acceleration flag from one sample.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_tilt_and_rate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,     // g_tolerance
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,    // raw_x, raw_y, raw_z, elapsed_us, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata     // pitch_deg, roll_deg, pitch_rate,
                                       // roll_rate, linear_accel, pad
);
  import atr_pkg::*;

  atr_state_e state_q, state_d;
  logic [13:0]        tol_q;
  logic signed [15:0] x_q, y_q, z_q, lp_q, lr_q, pitch_q, roll_q;
  logic [19:0]        e_q;
  logic [1:0]         sq_q;
  logic [33:0]        sum_q;
  logic               lin_q, sub_q;
  logic signed [23:0] prate_q, rrate_q;
  logic               cstart, cdone, dstart, ddone;
  logic signed [15:0] cnum, cden, cang;
  logic [DivNumW-1:0] dnum, dquot;
  logic signed [15:0] sqop;
  logic [31:0]        sqv;
  logic [15:0]        hi, lo;
  logic [31:0]        hi2, lo2;
  logic signed [16:0] delta;
  logic [16:0]        dabs;
  logic               dneg_q;
  logic [23:0]        qsat;
  logic signed [23:0] rate;

  atr_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .num_i(cnum), .den_i(cden),
    .done_o(cdone), .angle_o(cang)
  );

  atr_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(e_q),
    .done_o(ddone), .quot_o(dquot)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);

  // One square per cycle through a shared multiplier.
  always_comb begin
    case (sq_q)
      2'd0:    sqop = x_q;
      2'd1:    sqop = y_q;
      default: sqop = z_q;
    endcase
  end
  assign sqv = $unsigned(32'(sqop * sqop));
  assign hi  = 16'(OneG) + 16'(tol_q);
  assign lo  = 16'(OneG) - 16'(tol_q);
  assign hi2 = 32'(hi) * 32'(hi);
  assign lo2 = 32'(lo) * 32'(lo);

  // Rate operand: |delta| * 1e6 + elapsed/2 for round half away.
  assign delta = (state_q == StPRate) ? (17'(pitch_q) - 17'(lp_q))
                                      : (17'(roll_q) - 17'(lr_q));
  assign dabs  = delta[16] ? 17'(-delta) : 17'(delta);
  assign dnum  = DivNumW'(dabs) * DivNumW'(1000000) + DivNumW'(e_q >> 1);
  assign qsat  = (dquot > DivNumW'(24'h800000)) ? 24'h800000 : dquot[23:0];
  always_comb begin
    if (!dneg_q && qsat[23]) rate = 24'sh7FFFFF;
    else if (dneg_q)         rate = -$signed(qsat);
    else                     rate = $signed(qsat);
  end

  assign cnum   = (state_q == StRoll) ? y_q : x_q;
  assign cden   = z_q;
  assign cstart = sub_q && ((state_q == StPitch) || (state_q == StRoll));
  assign dstart = sub_q && ((state_q == StPRate) || (state_q == StRRate));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StSq;
      StSq:    if (sq_q == 2'd2) state_d = StMag;
      StMag:   state_d = StPitch;
      StPitch: if (cdone) state_d = StRoll;
      StRoll:  if (cdone) state_d = StPRate;
      StPRate: if (ddone) state_d = StRRate;
      StRRate: if (ddone) state_d = StOut;
      StOut:   if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tol_q   <= TolReset;
      lp_q    <= '0;
      lr_q    <= '0;
      sq_q    <= '0;
      sub_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sub_q   <= (state_d != state_q);
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      if (state_q == StSq) sq_q <= sq_q + 2'd1;
      else                 sq_q <= '0;
      if (state_q == StRRate && ddone) begin
        lp_q <= pitch_q;
        lr_q <= roll_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      x_q <= s_axis_tdata[15:0];
      y_q <= s_axis_tdata[31:16];
      z_q <= s_axis_tdata[47:32];
      e_q <= (s_axis_tdata[67:48] == '0) ? 20'd1 : s_axis_tdata[67:48];
      sum_q <= '0;
    end
    if (state_q == StSq) sum_q <= sum_q + 34'(sqv);
    if (state_q == StMag)
      lin_q <= !((sum_q <= 34'(hi2)) && (sum_q >= 34'(lo2)));
    if (state_q == StPitch && cdone) pitch_q <= cang;
    if (state_q == StRoll && cdone)  roll_q  <= cang;
    if (dstart) dneg_q <= delta[16];
    if (state_q == StPRate && ddone) prate_q <= rate;
    if (state_q == StRRate && ddone) rrate_q <= rate;
  end

  assign m_axis_tdata = {7'd0, lin_q, rrate_q, prate_q, roll_q, pitch_q};

  `ASSERT_IMPL(a_ready_idle, s_axis_tready, !m_axis_tvalid, "ready while result pending")
  `ASSERT_IMPL(a_start_busy, cstart, !dstart, "cordic and divider started together")
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
               "result dropped")

endmodule

// ===== hw/rtl/atr_cordic.sv =====
// ----------------------------------------------------------------------------
// atr_cordic
// Iterative vectoring CORDIC: one rotation per cycle, rounded and clamped
// angle in 1/128 degree.
// ----------------------------------------------------------------------------
module atr_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  num_i,
  input  logic signed [15:0]  den_i,
  output logic                done_o,
  output logic signed [15:0]  angle_o
);
  import atr_pkg::*;

  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic [StepW-1:0]          i_q, i_d;
  logic                      busy_q, busy_d, zero_q, zero_d, done_q, done_d;
  logic signed [CordicW-1:0] xs, ys, dx, dy;
  logic signed [AccW-1:0]    tab, rnd;
  logic signed [15:0]        ang;

  // Scaled operands; the preset negation for a negative denominator.
  assign xs = CordicW'(den_i) <<< 14;
  assign ys = CordicW'(num_i) <<< 14;
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign tab = $signed(atan_fine(i_q));

  always_comb begin
    x_d = x_q; y_d = y_q; acc_d = acc_q; i_d = i_q;
    busy_d = busy_q; zero_d = zero_q; done_d = 1'b0;
    if (start_i) begin
      zero_d = (num_i == '0) && (den_i == '0);
      busy_d = 1'b1;
      i_d    = '0;
      if (den_i < 0) begin
        x_d = -xs; y_d = -ys;
        acc_d = (num_i >= 0) ? Deg180Fine : -Deg180Fine;
      end else begin
        x_d = xs; y_d = ys; acc_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx; y_d = y_q - dy; acc_d = acc_q + tab;
      end else begin
        x_d = x_q - dx; y_d = y_q + dy; acc_d = acc_q - tab;
      end
      i_d = i_q + StepW'(1);
      if (i_q == StepW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; acc_q <= acc_d; zero_q <= zero_d;
  end

  // Round to 1/128 degree and clamp.
  assign rnd = (acc_q + AccW'(128)) >>> 8;
  always_comb begin
    if (rnd > AccW'(AngleLimit))       ang = AngleLimit;
    else if (rnd < -AccW'(AngleLimit)) ang = -AngleLimit;
    else                               ang = rnd[15:0];
  end

  assign done_o  = done_q;
  assign angle_o = zero_q ? '0 : ang;

endmodule

// ===== hw/rtl/atr_divider.sv =====
// ----------------------------------------------------------------------------
// atr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atr_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [atr_pkg::DivNumW-1:0]    num_i,
  input  logic [atr_pkg::DivDenW-1:0]    den_i,
  output logic                           done_o,
  output logic [atr_pkg::DivNumW-1:0]    quot_o
);
  import atr_pkg::*;

  logic [DivNumW-1:0] q_q, q_d;
  logic [DivDenW:0]   r_q, r_d, rs;
  logic [DivDenW-1:0] d_q;
  logic [DivCntW-1:0] c_q, c_d;
  logic               busy_q, busy_d, done_q, done_d;

  assign rs = {r_q[DivDenW-1:0], q_q[DivNumW-1]};

  always_comb begin
    q_d = q_q; r_d = r_q; c_d = c_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      q_d = num_i; r_d = '0; c_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (rs >= {1'b0, d_q}) begin
        r_d = rs - {1'b0, d_q};
        q_d = {q_q[DivNumW-2:0], 1'b1};
      end else begin
        r_d = rs;
        q_d = {q_q[DivNumW-2:0], 1'b0};
      end
      c_d = c_q + DivCntW'(1);
      if (c_q == DivCntW'(DivNumW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; c_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
    if (start_i) d_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== test/atr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atr_checker
// Watches both streams of the tilt and rate unit, computes the expected
// angles, rates and linear-acceleration flag of every accepted item and
// compares them with the results that come out.
// ----------------------------------------------------------------------------
module atr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic              linear_accel;
    logic signed [23:0] roll_rate;
    logic signed [23:0] pitch_rate;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
  } tilt_result_t;

  tilt_result_t      expected_tilts[$];
  logic [13:0]       tolerance;
  longint            prev_pitch;
  longint            prev_roll;

  localparam longint HalfTurnFine = 5898240;
  localparam longint AngleBound   = 23040;
  localparam longint RateHi       = 8388607;
  localparam longint RateLo       = -8388608;

  // Arctangent table, 1/32768 degree per count.
  localparam longint ArcTab[22] = '{1474560, 870484, 459940, 233473, 117189, 58652,
                                    29333, 14667, 7334, 3667, 1833, 917, 458, 229,
                                    115, 57, 29, 14, 7, 4, 2, 1};

  // Vectoring CORDIC angle of (den, num), rounded to 1/128 degree.
  function automatic longint cordic_angle(longint num, longint den);
    longint vx, vy, acc, sx, sy, r;
    acc = 0;
    if (num == 0 && den == 0) return 0;
    vx = den * 16384;
    vy = num * 16384;
    if (vx < 0) begin
      acc = (vy >= 0) ? HalfTurnFine : -HalfTurnFine;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < 22; i++) begin
      sx = vy >>> i;
      sy = vx >>> i;
      if (vy > 0) begin
        vx += sx;
        vy -= sy;
        acc += ArcTab[i];
      end else begin
        vx -= sx;
        vy += sy;
        acc -= ArcTab[i];
      end
    end
    r = (acc + 128) >>> 8;
    if (r > AngleBound) r = AngleBound;
    if (r < -AngleBound) r = -AngleBound;
    return r;
  endfunction

  // Angle change per second, rounded half away from zero and saturated.
  function automatic longint change_rate(longint delta, longint us);
    longint n, mag, q;
    n = delta * 1000000;
    mag = (n < 0) ? -n : n;
    q = (mag + us / 2) / us;
    q = (n < 0) ? -q : q;
    if (q > RateHi) q = RateHi;
    if (q < RateLo) q = RateLo;
    return q;
  endfunction

  function automatic tilt_result_t predict_tilt(logic [71:0] d);
    tilt_result_t res;
    longint ax, ay, az, us, sq, hi, lo, p, r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    us = longint'(d[67:48]);
    if (us == 0) us = 1;
    sq = ax * ax + ay * ay + az * az;
    hi = 16383 + longint'(tolerance);
    lo = 16383 - longint'(tolerance);
    p = cordic_angle(ax, az);
    r = cordic_angle(ay, az);
    res.pitch_deg    = p[15:0];
    res.roll_deg     = r[15:0];
    res.pitch_rate   = change_rate(p - prev_pitch, us);
    res.roll_rate    = change_rate(r - prev_roll, us);
    res.linear_accel = !((sq <= hi * hi) && (sq >= lo * lo));
    prev_pitch = p;
    prev_roll  = r;
    return res;
  endfunction

  assign pending_o = expected_tilts.size();

  // Follow the register, predict on each input item, compare each result item.
  always @(posedge clk_i or negedge rst_ni) begin
    tilt_result_t want, got;
    if (!rst_ni) begin
      tolerance    <= 14'd1638;
      prev_pitch   = 0;
      prev_roll    = 0;
      fail_count_o <= 0;
      expected_tilts.delete();
    end else begin
      if (cfg_we_i) tolerance <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) expected_tilts.push_back(predict_tilt(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = tilt_result_t'(m_axis_tdata[80:0]);
        if (expected_tilts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_tilts.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected p=%0d r=%0d pr=%0d rr=%0d la=%0b",
                     $time, want.pitch_deg, want.roll_deg, want.pitch_rate,
                     want.roll_rate, want.linear_accel);
            $display("%0t:          actual p=%0d r=%0d pr=%0d rr=%0d la=%0b",
                     $time, got.pitch_deg, got.roll_deg, got.pitch_rate,
                     got.roll_rate, got.linear_accel);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_accel_tilt_and_rate_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_and_rate_unit
// Drives samples into the tilt and rate unit with random gaps and output
// stalls, sweeps the tolerance register and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_accel_tilt_and_rate_unit;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [13:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          stim_done;

  localparam int WatchLimit = 4000;

  accel_tilt_and_rate_unit u_top (.*);

  atr_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Send one sample after a random gap; valid drops only during a gap.
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [19:0] us);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'd0, us, az, ay, ax};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Write the tolerance once the unit has drained.
  task automatic set_tolerance(logic [13:0] tol);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_wdata_i <= tol;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random component: any value, or within +/-20000, +/-12000 or +/-300.
  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 40000)) - 20000);
      2: return 16'($signed($urandom_range(0, 600)) - 300);
      default: return 16'($signed($urandom_range(0, 24000)) - 12000);
    endcase
  endfunction

  function automatic logic [19:0] rand_us();
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, 3));
      default: return 20'($urandom_range(500, 20000));
    endcase
  endfunction

  // Receiver stalls drawn per result item.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog on cycles without any accepted item.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (!stim_done)
        idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    logic [13:0] tols[5];
    int          n;
    stim_done     = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vector, axes, extremes, negative z, elapsed limits.
    send_sample(16'd0, 16'd0, 16'd0, 20'd0);
    send_sample(16'd0, 16'd0, 16'd16383, 20'd1000);
    send_sample(16'd16383, 16'd0, 16'd0, 20'd1);
    send_sample(16'h8000, 16'h8000, 16'h8000, 20'd0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 20'hfffff);
    send_sample(16'd1, 16'hffff, 16'hc001, 20'd10);
    send_sample(16'hffff, 16'd1, 16'hc001, 20'd10);
    send_sample(16'd0, 16'd0, 16'h8000, 20'd5);
    send_sample(16'd0, 16'd0, 16'd1, 20'd0);
    send_sample(16'h7fff, 16'h8000, 16'd0, 20'd3);
    send_sample(16'd18021, 16'd0, 16'd0, 20'd100);
    send_sample(16'd14745, 16'd0, 16'd0, 20'd100);
    send_sample(16'd18022, 16'd0, 16'd0, 20'd100);
    send_sample(16'd14744, 16'd0, 16'd0, 20'd100);

    // Random phases over several tolerances, extremes included.
    tols = '{14'd0, 14'd16383, 14'd1, 14'd800, 14'd4000};
    foreach (tols[k]) begin
      set_tolerance(tols[k]);
      if (k == 0) begin
        send_sample(16'd16383, 16'd0, 16'd0, 20'd7);
        send_sample(16'd16384, 16'd0, 16'd0, 20'd7);
      end
      n = (k == 4) ? 400 : 385;
      repeat (n) send_sample(rand_axis(), rand_axis(), rand_axis(), rand_us());
    end
    set_tolerance(14'($urandom));
    repeat (20) send_sample(rand_axis(), rand_axis(), rand_axis(), rand_us());
    s_axis_tvalid <= 1'b0;

    // Drain and settle.
    stim_done = 1'b1;
    n = 0;
    while (pending != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
